>>> src/sfr_pkg.sv
`default_nettype none

package sfr_pkg;

  localparam logic [7:0] TERM_FIRST  = 8'hFD;
  localparam logic [7:0] TERM_SECOND = 8'hFA;

  // Check word starts this many bytes before the length byte's count
  localparam logic [7:0] CHECK_OFFSET = 8'd6;
  localparam logic [7:0] CHECK_BYTES  = 8'd4;

  typedef enum logic [2:0] {
    ST_STORED   = 3'd0,
    ST_TERM1    = 3'd1,
    ST_COMPLETE = 3'd2,
    ST_BADTERM  = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_IGNORED  = 3'd5,
    ST_RELEASED = 3'd6
  } status_t;

  typedef struct packed {
    status_t    status;
    logic       payload_valid;
    logic [7:0] payload_index;
    logic [7:0] payload_byte;
    logic [7:0] frame_bytes;
    logic       check_ok;
  } result_t;

endpackage

`default_nettype wire

>>> src/sfr_frame.sv
`default_nettype none

module sfr_frame #(
  parameter int unsigned BUFFER_LENGTH = 256
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire logic             func,
  input  wire logic [7:0]       rx_byte,
  output sfr_pkg::result_t      res
);

  logic [7:0]  cnt_r, cnt_nxt;
  logic        term_r, term_nxt;
  logic        done_r, done_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [31:0] sum_r, sum_nxt;
  logic [31:0] chk_r, chk_nxt;

  logic [7:0]  len_eff;
  logic [7:0]  start;
  logic [7:0]  diff;
  logic        in_win;
  logic        add_ok;
  logic        last;
  logic [31:0] shifted;

  always_comb begin
    // first payload byte is the length byte
    len_eff = (cnt_r == 8'd0) ? rx_byte : len_r;
    start   = (len_eff > sfr_pkg::CHECK_OFFSET) ? (len_eff - sfr_pkg::CHECK_OFFSET) : 8'd0;
    diff    = cnt_r - start;
    in_win  = (cnt_r >= start) && (diff < sfr_pkg::CHECK_BYTES);
    // big-endian: window offset 0 lands in the top byte
    shifted = {24'd0, rx_byte} << {~diff[1:0], 3'b000};
    add_ok  = ({1'b0, cnt_r} + {1'b0, sfr_pkg::CHECK_OFFSET}) < {1'b0, len_eff};
    last    = ({1'b0, cnt_r} == 9'(BUFFER_LENGTH - 1));

    cnt_nxt  = cnt_r;
    term_nxt = term_r;
    done_nxt = done_r;
    len_nxt  = len_r;
    sum_nxt  = sum_r;
    chk_nxt  = chk_r;

    res               = '0;
    res.status        = sfr_pkg::ST_STORED;

    priority if (func) begin
      cnt_nxt    = '0;
      term_nxt   = 1'b0;
      done_nxt   = 1'b0;
      len_nxt    = '0;
      sum_nxt    = '0;
      chk_nxt    = '0;
      res.status = sfr_pkg::ST_RELEASED;
    end else if (done_r) begin
      res.status = sfr_pkg::ST_IGNORED;
    end else if (term_r) begin
      if (rx_byte != sfr_pkg::TERM_SECOND) begin
        cnt_nxt    = '0;
        term_nxt   = 1'b0;
        done_nxt   = 1'b0;
        len_nxt    = '0;
        sum_nxt    = '0;
        chk_nxt    = '0;
        res.status = sfr_pkg::ST_BADTERM;
      end else begin
        done_nxt     = 1'b1;
        res.check_ok = (sum_r == chk_r);
        res.status   = sfr_pkg::ST_COMPLETE;
      end
    end else if (rx_byte == sfr_pkg::TERM_FIRST) begin
      term_nxt   = 1'b1;
      res.status = sfr_pkg::ST_TERM1;
    end else begin
      res.payload_valid = 1'b1;
      res.payload_index = cnt_r;
      res.payload_byte  = rx_byte;
      if (last) begin
        cnt_nxt    = '0;
        term_nxt   = 1'b0;
        done_nxt   = 1'b0;
        len_nxt    = '0;
        sum_nxt    = '0;
        chk_nxt    = '0;
        res.status = sfr_pkg::ST_OVERFLOW;
      end else begin
        cnt_nxt    = cnt_r + 8'd1;
        len_nxt    = len_eff;
        sum_nxt    = add_ok ? (sum_r + {24'd0, rx_byte}) : sum_r;
        chk_nxt    = in_win ? (chk_r | shifted) : chk_r;
        res.status = sfr_pkg::ST_STORED;
      end
    end

    res.frame_bytes = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      term_r <= 1'b0;
      done_r <= 1'b0;
      len_r  <= '0;
      sum_r  <= '0;
      chk_r  <= '0;
    end else if (step) begin
      cnt_r  <= cnt_nxt;
      term_r <= term_nxt;
      done_r <= done_nxt;
      len_r  <= len_nxt;
      sum_r  <= sum_nxt;
      chk_r  <= chk_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/serial_frame_receiver_with_sum_check.sv
// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall   func, rx_byte
// out_      output     out_valid/out_stall status, payload_valid, payload_index,
//                                          payload_byte, frame_bytes, check_ok
//
// One word per cycle sustained while out_stall is low; each word passes the input
// register, then the result register, with the single frame-state update between them.
// Synchronous reset clears the frame state and both valid flags.
// An out_stall held while out_valid is high stops the result register; in_stall rises
// once the input register is also occupied.
`default_nettype none

module serial_frame_receiver_with_sum_check #(
  parameter int unsigned BUFFER_LENGTH = 256
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_func,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_status,
  output logic            out_payload_valid,
  output logic [7:0]      out_payload_index,
  output logic [7:0]      out_payload_byte,
  output logic [7:0]      out_frame_bytes,
  output logic            out_check_ok
);

  logic             s1_valid_r;
  logic             s1_func_r;
  logic [7:0]       s1_byte_r;
  logic             out_valid_r;
  sfr_pkg::result_t out_res_r;
  sfr_pkg::result_t res;
  logic             adv;
  logic             step;

  assign adv      = !out_valid_r || !out_stall;
  assign step     = s1_valid_r && adv;
  assign in_stall = s1_valid_r && !adv;

  sfr_frame #(
    .BUFFER_LENGTH(BUFFER_LENGTH)
  ) u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .func    (s1_func_r),
    .rx_byte (s1_byte_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_func_r <= in_func;
      s1_byte_r <= in_rx_byte;
    end
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_res_r.status;
  assign out_payload_valid = out_res_r.payload_valid;
  assign out_payload_index = out_res_r.payload_index;
  assign out_payload_byte  = out_res_r.payload_byte;
  assign out_frame_bytes   = out_res_r.frame_bytes;
  assign out_check_ok      = out_res_r.check_ok;

  a_payload_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_payload_valid) |->
      (out_status == sfr_pkg::ST_STORED || out_status == sfr_pkg::ST_OVERFLOW))
    else $error("payload word with non-storing status");

  a_check_only_complete: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_check_ok) |-> (out_status == sfr_pkg::ST_COMPLETE))
    else $error("check_ok outside frame completion");

  a_stored_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == sfr_pkg::ST_STORED) |->
      (out_frame_bytes == out_payload_index + 8'd1))
    else $error("frame count does not follow stored index");

  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == sfr_pkg::ST_OVERFLOW) |->
      (out_frame_bytes == 8'd0 && out_payload_index == 8'(BUFFER_LENGTH - 1)))
    else $error("overflow restart at wrong position");

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int BUF_LEN      = 256;
  localparam int IDLE_LIMIT   = 200;
  localparam int RANDOM_WORDS = 330;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_func = 1'b0;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] out_status;
  logic       out_payload_valid;
  logic [7:0] out_payload_index;
  logic [7:0] out_payload_byte;
  logic [7:0] out_frame_bytes;
  logic       out_check_ok;

  // Mirror of the frame state
  logic [7:0]  rx_count;
  logic        fd_pending;
  logic        frame_held;
  logic [7:0]  len_byte;
  logic [31:0] sum_acc;
  logic [31:0] check_acc;

  sfr_pkg::result_t rx_results_due[$];
  int      mismatches = 0;
  int      words_counted = 0;
  int      quiet_cycles = 0;
  bit      steady = 1'b0;

  serial_frame_receiver_with_sum_check #(
    .BUFFER_LENGTH(BUF_LEN)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_payload_valid(out_payload_valid),
    .out_payload_index(out_payload_index),
    .out_payload_byte (out_payload_byte),
    .out_frame_bytes  (out_frame_bytes),
    .out_check_ok     (out_check_ok)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic clear_frame_state();
    rx_count   = 8'd0;
    fd_pending = 1'b0;
    frame_held = 1'b0;
    len_byte   = 8'd0;
    sum_acc    = 32'd0;
    check_acc  = 32'd0;
  endtask

  // Sum covers positions below len-6; check word sits big-endian at max(len-6,0)
  task automatic fold_byte(input logic [7:0] pos, input logic [7:0] b);
    int start;
    if (pos == 8'd0) len_byte = b;
    if (int'(pos) + int'(sfr_pkg::CHECK_OFFSET) < int'(len_byte)) sum_acc += 32'(b);
    start = (len_byte > sfr_pkg::CHECK_OFFSET) ?
            int'(len_byte) - int'(sfr_pkg::CHECK_OFFSET) : 0;
    if (int'(pos) >= start && int'(pos) < start + int'(sfr_pkg::CHECK_BYTES))
      check_acc |= 32'(b) << (8 * (3 - (int'(pos) - start)));
  endtask

  task automatic deframe_word(input logic func, input logic [7:0] b);
    sfr_pkg::result_t r;
    int      nxt;
    r = '0;
    if (func) begin
      clear_frame_state();
      r.status = sfr_pkg::ST_RELEASED;
    end else if (frame_held) begin
      r.status = sfr_pkg::ST_IGNORED;
    end else if (fd_pending) begin
      if (b != sfr_pkg::TERM_SECOND) begin
        clear_frame_state();
        r.status = sfr_pkg::ST_BADTERM;
      end else begin
        frame_held = 1'b1;
        r.check_ok = (sum_acc == check_acc);
        r.status = sfr_pkg::ST_COMPLETE;
      end
    end else if (b == sfr_pkg::TERM_FIRST) begin
      fd_pending = 1'b1;
      r.status = sfr_pkg::ST_TERM1;
    end else begin
      fold_byte(rx_count, b);
      r.payload_valid = 1'b1;
      r.payload_index = rx_count;
      r.payload_byte  = b;
      nxt = int'(rx_count) + 1;
      if (nxt > BUF_LEN - 1) begin
        clear_frame_state();
        r.status = sfr_pkg::ST_OVERFLOW;
      end else begin
        rx_count = 8'(nxt);
        r.status = sfr_pkg::ST_STORED;
      end
    end
    r.frame_bytes = rx_count;
    if (r.status != sfr_pkg::ST_IGNORED) words_counted++;
    rx_results_due.push_back(r);
  endtask

  task automatic send_word(input logic func, input logic [7:0] b);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_func    <= func;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    deframe_word(func, b);
  endtask

  // Always waits for the clock before checking the queue, so in_valid never gets two updates in a step
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (rx_results_due.size() != 0);
  endtask

  function automatic logic [7:0] any_data_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 254));
    if (b >= sfr_pkg::TERM_FIRST) b = b + 8'd1;
    return b;
  endfunction

  task automatic release_frame();
    send_word(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_noise(input int count);
    int k;
    int pick;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 19);
      if (pick < 2) send_word(1'b1, 8'($urandom_range(0, 255)));
      else if (pick < 6) send_word(1'b0, sfr_pkg::TERM_FIRST);
      else if (pick < 8) send_word(1'b0, sfr_pkg::TERM_SECOND);
      else send_word(1'b0, 8'($urandom_range(0, 255)));
    end
  endtask

  // Frame after a release: length byte, summed body, check word, terminator; corrupt flips one bit
  task automatic send_frame(input int len, input bit corrupt);
    logic [7:0]  body[$];
    logic [31:0] sum;
    int          k;
    bit          clean;
    if (len == int'(sfr_pkg::TERM_FIRST)) len++;
    do begin
      body.delete();
      body.push_back(8'(len));
      for (k = 1; k < len - int'(sfr_pkg::CHECK_OFFSET); k++)
        body.push_back(any_data_byte());
      sum = '0;
      foreach (body[i]) sum += 32'(body[i]);
      clean = 1'b1;
      for (k = 0; k < 4; k++) if (sum[8*k +: 8] == sfr_pkg::TERM_FIRST) clean = 1'b0;
    end while (!clean);
    for (k = 3; k >= 0; k--) body.push_back(sum[8*k +: 8]);
    if (corrupt) begin
      k = $urandom_range(0, body.size() - 1);
      body[k] = body[k] ^ (8'd1 << $urandom_range(0, 7));
      if (body[k] == sfr_pkg::TERM_FIRST) body[k] = 8'hFE;
    end
    release_frame();
    foreach (body[i]) send_word(1'b0, body[i]);
    send_word(1'b0, sfr_pkg::TERM_FIRST);
    send_word(1'b0, sfr_pkg::TERM_SECOND);
  endtask

  task automatic send_broken_frame(input int len);
    int k;
    release_frame();
    send_word(1'b0, 8'(len));
    for (k = $urandom_range(0, len - 3); k > 0; k--) send_word(1'b0, any_data_byte());
    case ($urandom_range(0, 2))
      0: begin
        send_word(1'b0, sfr_pkg::TERM_FIRST);
        send_word(1'b0, ($urandom_range(0, 1) == 0) ? sfr_pkg::TERM_FIRST : any_data_byte());
      end
      1: release_frame();
      default: begin
        send_word(1'b0, sfr_pkg::TERM_FIRST);
        send_word(1'b0, sfr_pkg::TERM_SECOND);
      end
    endcase
  endtask

  task automatic test_terminator_cases();
    send_word(1'b1, 8'h00);                 // release with no frame held
    send_word(1'b0, sfr_pkg::TERM_FIRST);   // empty frame: zero sum, zero check word
    send_word(1'b0, sfr_pkg::TERM_SECOND);
    send_word(1'b0, 8'h55);                 // ignored while held
    send_word(1'b1, 8'hFF);
    send_word(1'b0, 8'hFF);
    send_word(1'b0, 8'h00);
    send_word(1'b0, sfr_pkg::TERM_SECOND);  // 0xFA alone is plain payload
    send_word(1'b0, sfr_pkg::TERM_FIRST);
    send_word(1'b0, 8'h00);                 // bad terminator
    send_word(1'b0, sfr_pkg::TERM_FIRST);
    send_word(1'b0, sfr_pkg::TERM_FIRST);   // 0xFD twice also restarts
    send_word(1'b0, 8'h07);                 // check word positions never received
    send_word(1'b0, sfr_pkg::TERM_FIRST);
    send_word(1'b0, sfr_pkg::TERM_SECOND);
    send_frame(7, 1'b0);
    send_frame(12, 1'b1);
  endtask

  task automatic test_max_length();
    send_frame(255, 1'b0);
    send_frame(254, 1'b0);
    send_frame(252, 1'b1);
  endtask

  task automatic test_overflow();
    int k;
    release_frame();
    for (k = 0; k < BUF_LEN; k++) send_word(1'b0, any_data_byte());
    send_word(1'b0, 8'h01);
    send_word(1'b0, sfr_pkg::TERM_FIRST);
    send_word(1'b0, sfr_pkg::TERM_SECOND);
  endtask

  task automatic test_pause_until_drained();
    int k;
    release_frame();
    send_word(1'b0, 8'd9);
    for (k = 0; k < 4; k++) send_word(1'b0, any_data_byte());
    wait_drained();
    send_word(1'b0, sfr_pkg::TERM_FIRST);
    wait_drained();
    send_word(1'b0, sfr_pkg::TERM_SECOND);
  endtask

  task automatic test_random_traffic();
    int kind;
    int len;
    words_counted = 0;
    while (words_counted < RANDOM_WORDS) begin
      if ($urandom_range(0, 7) == 0) steady = !steady;
      kind = $urandom_range(0, 9);
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 255) : $urandom_range(7, 24);
      if (kind < 6) send_frame(len, 1'b0);
      else if (kind < 7) send_frame(len, 1'b1);
      else if (kind < 9) send_broken_frame(len);
      else send_noise($urandom_range(1, 12));
      if (frame_held && $urandom_range(0, 3) == 0) send_noise($urandom_range(1, 3));
    end
    steady = 1'b0;
  endtask

  // Result check and receiver stall
  always @(posedge clk) begin : check_results
    sfr_pkg::result_t got;
    sfr_pkg::result_t want;
    int      stall_left;
    if (!rst_n) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.status        = sfr_pkg::status_t'(out_status);
        got.payload_valid = out_payload_valid;
        got.payload_index = out_payload_index;
        got.payload_byte  = out_payload_byte;
        got.frame_bytes   = out_frame_bytes;
        got.check_ok      = out_check_ok;
        if (rx_results_due.size() == 0) begin
          $display("%0t: unexpected word, status %0d", $time, out_status);
          mismatches++;
        end else begin
          want = rx_results_due.pop_front();
          if (got !== want) begin
            $display("%0t: expected status %0d valid %0b index %0d byte %02h count %0d ok %0b",
                     $time, want.status, want.payload_valid, want.payload_index,
                     want.payload_byte, want.frame_bytes, want.check_ok);
            $display("%0t: actual   status %0d valid %0b index %0d byte %02h count %0d ok %0b",
                     $time, got.status, got.payload_valid, got.payload_index,
                     got.payload_byte, got.frame_bytes, got.check_ok);
            mismatches++;
          end
        end
        stall_left = steady ? 0 : $urandom_range(0, 7);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    clear_frame_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_terminator_cases();
    test_max_length();
    test_overflow();
    test_pause_until_drained();
    test_random_traffic();
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
